### rtl/core/ssrp_pkg.sv
// Shared types and constants for the servo slew ramp and pulse width block.
// Holds the payload word formats, action and status codes, and the divider
// reciprocals. No dependencies.
package ssrp_pkg;

  // Default channel count
  localparam int CHANNELS_DEF = 3;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int SERVO_W = 3;
  localparam int ANGLE_W = 9;
  localparam int MDEG_W  = 19;
  localparam int US_W    = 11;
  localparam int PULSE_W = 12;
  localparam int STAT_W  = 2;
  localparam int OUTS    = 3;
  localparam int CFG_IDX_W = 2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_SET  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_SERVO = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_ANGLE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE = 2'd2;

  // Configuration reset values
  localparam logic [MDEG_W-1:0] STEP_RST  = 19'd600;
  localparam logic [US_W-1:0]   MIN_RST   = 11'd500;
  localparam logic [US_W-1:0]   RANGE_RST = 11'd2000;

  // Angle scaling and limits
  localparam logic [MDEG_W-1:0] MDEG_PER_DEG = 19'd1000;
  localparam logic [MDEG_W-1:0] LIMIT_WIDE   = 19'd360000;
  localparam logic [MDEG_W-1:0] LIMIT_NARROW = 19'd270000;
  localparam logic [SERVO_W-1:0] FIRST_SERVO = 3'd2;
  localparam int WIDE_CH = 2;

  // Exact divide by limit: floor(p / d) = (p * M) >> 49 for p < 2**30,
  // with M = ceil(2**49 / d), d below 2**19
  localparam int PROD_W   = MDEG_W + US_W;   // 30
  localparam int RECIP_SH = 49;
  localparam int RECIP_W  = 31;
  localparam logic [RECIP_W-1:0] RECIP_WIDE =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd360000 - 64'd1) / 64'd360000);
  localparam logic [RECIP_W-1:0] RECIP_NARROW =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd270000 - 64'd1) / 64'd270000);

  // Input word
  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [SERVO_W-1:0] servo_number;
    logic [ANGLE_W-1:0] angle_deg;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               now_moving;
    logic [PULSE_W-1:0] pulse_first;
    logic [PULSE_W-1:0] pulse_second;
    logic [PULSE_W-1:0] pulse_third;
    logic [OUTS-1:0]    enabled_mask;
    logic [OUTS-1:0]    moving_mask;
    logic [OUTS-1:0]    done_mask;
  } out_word_t;

endpackage

### rtl/core/servo_slew_ramp_pwm.sv
// Servo slew ramp generator with pulse width readout, top level.
// Depends on ssrp_pkg for word formats, codes and divider constants.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_valid/in_stall   | in_data  (in_word_t)
//   out_    | out | out_valid/out_stall | out_data (out_word_t)
//   cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// One word per cycle while the output is not stalled; each result passes through
// stage 1, stage 2 and the output register. Channel state updates at the input edge; the pulse width then
// takes a multiply stage and a reciprocal-multiply stage.
// Synchronous active-low reset clears channel state and loads register defaults.
// Each stage holds while the one after it is full and stalled; input is taken
// whenever the first stage is free.
module servo_slew_ramp_pwm
  import ssrp_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MDEG_W-1:0]    cfg_wdata
);

  localparam logic [SERVO_W:0] CH_COUNT = (SERVO_W+1)'(CHANNELS);

  // Configuration registers
  logic [MDEG_W-1:0] step_r;
  logic [US_W-1:0]   min_r;
  logic [US_W-1:0]   range_r;

  // Channel state
  logic [MDEG_W-1:0]   cur_r   [CHANNELS];
  logic [MDEG_W-1:0]   tgt_r   [CHANNELS];
  logic [CHANNELS-1:0] en_r;
  logic [CHANNELS-1:0] mv_r;
  logic [MDEG_W-1:0]   cur_nxt [CHANNELS];
  logic [MDEG_W-1:0]   tgt_nxt [CHANNELS];
  logic [CHANNELS-1:0] en_nxt;
  logic [CHANNELS-1:0] mv_nxt;
  logic [CHANNELS-1:0] done_nxt;
  logic [CHANNELS-1:0] start_mv;

  // Pipeline control
  logic v1_r, v2_r, out_valid_r;
  logic free1, free2, free3, in_acc;

  // Decode of the incoming word
  logic [SERVO_W-1:0] ch_sel;
  logic               servo_ok;
  logic               angle_ok;
  logic [MDEG_W-1:0]  new_tgt;
  logic [STAT_W-1:0]  status_nxt;

  // Per-output-slot views of the new state
  logic [MDEG_W-1:0] slot_cur [OUTS];
  logic [OUTS-1:0]   slot_en, slot_mv, slot_done;

  // Stage 1: snapshot after state update
  logic [STAT_W-1:0] stat1_r;
  logic              nm1_r;
  logic [OUTS-1:0]   en1_r, mv1_r, done1_r;
  logic [MDEG_W-1:0] cur1_r [OUTS];

  // Stage 2: angle times range
  logic [STAT_W-1:0] stat2_r;
  logic              nm2_r;
  logic [OUTS-1:0]   en2_r, mv2_r, done2_r;
  logic [PROD_W-1:0] prod2_r [OUTS];

  // Stage 3 inputs: divide by limit through the reciprocal, add offset
  logic [PULSE_W-1:0] pulse3 [OUTS];
  out_word_t          out_r;

  // Handshake: a stage moves when the next one is empty or moving
  assign free3    = !out_valid_r || !out_stall;
  assign free2    = !v2_r || free3;
  assign free1    = !v1_r || free2;
  assign in_stall = !free1;
  assign in_acc   = in_valid && free1;

  // Decode servo number and angle limit
  always_comb begin
    ch_sel   = in_data.servo_number - FIRST_SERVO;
    servo_ok = (in_data.servo_number >= FIRST_SERVO) && ({1'b0, ch_sel} < CH_COUNT);
    new_tgt  = MDEG_W'(in_data.angle_deg) * MDEG_PER_DEG;
    if (ch_sel == SERVO_W'(WIDE_CH)) begin
      angle_ok = new_tgt <= LIMIT_WIDE;
    end else begin
      angle_ok = new_tgt <= LIMIT_NARROW;
    end
    status_nxt = STAT_OK;
    if (in_data.action == ACT_SET) begin
      if (!servo_ok) begin
        status_nxt = STAT_BAD_SERVO;
      end else if (!angle_ok) begin
        status_nxt = STAT_BAD_ANGLE;
      end
    end
  end

  // Next channel state, each channel on its own
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      cur_nxt[i]  = cur_r[i];
      tgt_nxt[i]  = tgt_r[i];
      en_nxt[i]   = en_r[i];
      mv_nxt[i]   = mv_r[i];
      done_nxt[i] = 1'b0;
      start_mv[i] = 1'b0;
      case (in_data.action)
        ACT_SET: begin
          if (servo_ok && angle_ok && ch_sel == SERVO_W'(i)) begin
            tgt_nxt[i] = new_tgt;
            if (!en_r[i]) begin
              cur_nxt[i] = new_tgt;
              mv_nxt[i]  = 1'b0;
              en_nxt[i]  = 1'b1;
            end else begin
              mv_nxt[i]   = cur_r[i] != new_tgt;
              start_mv[i] = cur_r[i] != new_tgt;
            end
          end
        end
        ACT_TICK: begin
          if (en_r[i] && mv_r[i]) begin
            // step toward target, clamp on arrival
            if (cur_r[i] < tgt_r[i]) begin
              cur_nxt[i] = (tgt_r[i] - cur_r[i] <= step_r) ? tgt_r[i] : cur_r[i] + step_r;
            end else begin
              cur_nxt[i] = (cur_r[i] - tgt_r[i] <= step_r) ? tgt_r[i] : cur_r[i] - step_r;
            end
            if (cur_nxt[i] == tgt_r[i]) begin
              mv_nxt[i]   = 1'b0;
              done_nxt[i] = 1'b1;
            end
          end
        end
        ACT_STOP: begin
          tgt_nxt[i] = cur_r[i];
          mv_nxt[i]  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Map channels onto the three reported slots
  for (genvar k = 0; k < OUTS; k++) begin : g_slot
    if (k < CHANNELS) begin : g_on
      assign slot_cur[k]  = cur_nxt[k];
      assign slot_en[k]   = en_nxt[k];
      assign slot_mv[k]   = mv_nxt[k];
      assign slot_done[k] = done_nxt[k];
    end else begin : g_off
      assign slot_cur[k]  = '0;
      assign slot_en[k]   = 1'b0;
      assign slot_mv[k]   = 1'b0;
      assign slot_done[k] = 1'b0;
    end
  end

  // Reciprocal multiply, drop fraction, add minimum pulse
  always_comb begin
    for (int k = 0; k < OUTS; k++) begin
      logic [PROD_W+RECIP_W-1:0] q_full;
      logic [RECIP_W-1:0]        recip;
      recip  = (k == WIDE_CH) ? RECIP_WIDE : RECIP_NARROW;
      q_full = (PROD_W+RECIP_W)'(prod2_r[k]) * (PROD_W+RECIP_W)'(recip);
      if (en2_r[k]) begin
        pulse3[k] = PULSE_W'(min_r) + PULSE_W'(q_full[RECIP_SH +: US_W]);
      end else begin
        pulse3[k] = '0;
      end
    end
  end

  // Configuration, channel state and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RST;
      min_r       <= MIN_RST;
      range_r     <= RANGE_RST;
      en_r        <= '0;
      mv_r        <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        cur_r[i] <= '0;
        tgt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP:  step_r  <= cfg_wdata;
          CFG_MIN:   min_r   <= cfg_wdata[US_W-1:0];
          CFG_RANGE: range_r <= cfg_wdata[US_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        en_r <= en_nxt;
        mv_r <= mv_nxt;
        for (int i = 0; i < CHANNELS; i++) begin
          cur_r[i] <= cur_nxt[i];
          tgt_r[i] <= tgt_nxt[i];
        end
      end
      if (free1) begin
        v1_r <= in_acc;
      end
      if (free2) begin
        v2_r <= v1_r;
      end
      if (free3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stat1_r <= status_nxt;
      nm1_r   <= |start_mv;
      en1_r   <= slot_en;
      mv1_r   <= slot_mv;
      done1_r <= slot_done;
      for (int k = 0; k < OUTS; k++) begin
        cur1_r[k] <= slot_cur[k];
      end
    end
    if (free2 && v1_r) begin
      stat2_r <= stat1_r;
      nm2_r   <= nm1_r;
      en2_r   <= en1_r;
      mv2_r   <= mv1_r;
      done2_r <= done1_r;
      for (int k = 0; k < OUTS; k++) begin
        prod2_r[k] <= PROD_W'(cur1_r[k]) * PROD_W'(range_r);
      end
    end
    if (free3 && v2_r) begin
      out_r.status       <= stat2_r;
      out_r.now_moving   <= nm2_r;
      out_r.pulse_first  <= pulse3[0];
      out_r.pulse_second <= pulse3[1];
      out_r.pulse_third  <= pulse3[2];
      out_r.enabled_mask <= en2_r;
      out_r.moving_mask  <= mv2_r;
      out_r.done_mask    <= done2_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // A rejected command neither starts motion nor reports arrivals
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |->
      !out_data.now_moving && out_data.done_mask == '0)
    else $error("error status with motion flags");

  // Only enabled channels can be ramping
  a_mv_en: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.moving_mask & ~out_data.enabled_mask) == '0)
    else $error("moving channel not enabled");

  // A channel that arrived is no longer ramping
  a_done_mv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.done_mask & out_data.moving_mask) == '0)
    else $error("done and moving together");

  // Stop all halts every channel by the next cycle
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.action == ACT_STOP |=> mv_r == '0)
    else $error("motion left after stop all");

  // Disabled first channel reports no pulse
  a_pulse_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.enabled_mask[0] |-> out_data.pulse_first == '0)
    else $error("pulse on disabled channel");
`endif

endmodule
